// ----- rtl/core/dfrq_pkg.sv -----
// shared types and constants of the delayed frame release queue
// no dependencies
package dfrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEPS   = 17;
	localparam int DSTEP_W     = 5;

	localparam logic [1:0] REG_QUANT_STEP  = 2'd0;
	localparam logic [1:0] REG_ANTI_REWIND = 2'd1;
	localparam logic [1:0] REG_MAX_FRAMES  = 2'd2;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef struct packed {
		logic [32:0] rel;
		logic [31:0] cap;
		logic [14:0] dly;
		logic [15:0] tag;
		logic [11:0] wid;
		logic [11:0] hgt;
		logic [31:0] ord;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [9:0] quant_step;
		logic       anti_rewind;
		logic [4:0] max_frames;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_MUL, ST_CHECK, ST_SCAN_RD, ST_SCAN_CMP,
		ST_DUE, ST_RM_RD, ST_RM_WR, ST_INSERT, ST_RESULT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mul;
		logic scan_clr;
		logic scan_rd;
		logic scan_cmp;
		logic apply;
		logic rm_rd;
		logic rm_wr;
		logic insert;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic is_add;
		logic div_bypass;
		logic div_done;
		logic occ_nonzero;
		logic need_drop;
		logic scan_last;
		logic due;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/core/dfrq_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module dfrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/dfrq_ctrl.sv -----
// controller state machine of the delayed frame release queue
// depends on dfrq_pkg
module dfrq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dfrq_pkg::status_t status,
	output dfrq_pkg::cmd_t    cmd
);
	import dfrq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				state_d = ST_CHECK;
				if (status.is_add) begin
					state_d = ST_MUL;
					if (!status.div_bypass && !status.div_done) begin
						cmd.div_step = 1'b1;
						state_d      = ST_DIV;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.is_add) begin
					state_d = ST_INSERT;
					if (status.need_drop) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN_RD;
					end
				end else begin
					state_d = ST_RESULT;
					if (status.occ_nonzero) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = ST_SCAN_RD;
				if (status.scan_last) begin
					state_d = status.is_add ? ST_RM_RD : ST_DUE;
				end
			end
			ST_DUE: begin
				state_d = ST_RESULT;
				if (status.due) begin
					cmd.apply = 1'b1;
					state_d   = ST_RM_RD;
				end
			end
			ST_RM_RD: begin
				cmd.rm_rd = 1'b1;
				state_d   = ST_RM_WR;
			end
			ST_RM_WR: begin
				cmd.rm_wr = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ----- rtl/core/dfrq_dp.sv -----
// datapath: entry store, quantizing divider, scan and frame registers
// depends on dfrq_pkg and dfrq_ram
module dfrq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dfrq_pkg::cfg_t    cfg,
	input  dfrq_pkg::cmd_t    cmd,
	output dfrq_pkg::status_t status,
	input  logic              operation,
	input  logic [31:0]       now_time,
	input  logic signed [15:0] delay_ms,
	input  logic [15:0]       frame_tag,
	input  logic [11:0]       frame_width,
	input  logic [11:0]       frame_height,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              frame_valid,
	output logic [15:0]       out_tag,
	output logic [11:0]       out_width,
	output logic [11:0]       out_height,
	output logic [31:0]       out_source_time,
	output logic [14:0]       out_delay,
	output logic [14:0]       expected_delay,
	output logic [4:0]        dropped_count,
	output logic [4:0]        queue_count
);
	import dfrq_pkg::*;

	logic        op_q;
	logic [31:0] now_q;
	logic [15:0] draw_q;
	logic [15:0] tag_q;
	logic [11:0] wid_q;
	logic [11:0] hgt_q;

	logic [11:0]        rem_q;
	logic [16:0]        num_q;
	logic [16:0]        quo_q;
	logic [DSTEP_W-1:0] dcnt_q;
	logic [14:0]        delay_q;

	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] drop_q;
	logic [31:0]      arrival_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;

	logic        any_q;
	logic [31:0] last_cap_q;
	logic [14:0] last_delay_q;
	logic [15:0] lf_tag_q;
	logic [11:0] lf_wid_q;
	logic [11:0] lf_hgt_q;
	logic [31:0] lf_cap_q;
	logic [14:0] lf_dly_q;
	logic        out_valid_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	logic [11:0] den;
	logic [11:0] trial;
	logic [26:0] prod;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] occ_m1;
	logic        rd_first;
	logic        skip;
	entry_t      new_entry;

	assign den   = {1'b0, cfg.quant_step, 1'b0};
	assign trial = {rem_q[10:0], num_q[16]};
	assign prod  = quo_q * cfg.quant_step;
	assign limit = (cfg.max_frames > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
		: cfg.max_frames;
	assign occ_m1 = occ_q - CNT_W'(1);

	always_comb begin
		rd_first = 1'b0;
		if (scan_idx_q == '0) begin
			rd_first = 1'b1;
		end else if (ram_rdata.rel != best_q.rel) begin
			rd_first = ram_rdata.rel < best_q.rel;
		end else begin
			rd_first = ram_rdata.ord[31] ^ best_q.ord[31] ?
				1'(((ram_rdata.ord - best_q.ord) >> 31)) :
				1'(((ram_rdata.ord - best_q.ord) >> 31));
		end
	end

	assign skip = cfg.anti_rewind && any_q && (best_q.cap < last_cap_q);

	always_comb begin
		new_entry     = '0;
		new_entry.rel = {1'b0, now_q} + {18'd0, delay_q};
		new_entry.cap = now_q;
		new_entry.dly = delay_q;
		new_entry.tag = tag_q;
		new_entry.wid = wid_q;
		new_entry.hgt = hgt_q;
		new_entry.ord = arrival_q;
	end

	assign ram_we    = cmd.rm_wr | cmd.insert;
	assign ram_waddr = cmd.insert ? occ_q[IDX_W-1:0] : best_idx_q;
	assign ram_wdata = cmd.insert ? new_entry : ram_rdata;
	assign ram_raddr = cmd.rm_rd ? occ_m1[IDX_W-1:0] : scan_idx_q;

	dfrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			now_q  <= now_time;
			draw_q <= delay_ms;
			tag_q  <= frame_tag;
			wid_q  <= frame_width;
			hgt_q  <= frame_height;
			rem_q  <= '0;
			quo_q  <= '0;
			num_q  <= {delay_ms[15:0], 1'b0} + {7'd0, cfg.quant_step};
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[15:0], 1'b0};
			dcnt_q <= dcnt_q + DSTEP_W'(1);
			if (trial >= den) begin
				rem_q <= trial - den;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
		if (cmd.mul) begin
			if (draw_q[15]) begin
				delay_q <= '0;
			end else if (cfg.quant_step == '0) begin
				delay_q <= draw_q[14:0];
			end else if (prod > 27'd32767) begin
				delay_q <= 15'h7fff;
			end else begin
				delay_q <= prod[14:0];
			end
		end
		if (cmd.scan_cmp && rd_first) begin
			best_q     <= ram_rdata;
			best_idx_q <= scan_idx_q;
		end
		if (cmd.apply && !skip) begin
			lf_tag_q <= best_q.tag;
			lf_wid_q <= best_q.wid;
			lf_hgt_q <= best_q.hgt;
			lf_dly_q <= best_q.dly;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q        <= '0;
			drop_q       <= '0;
			arrival_q    <= '0;
			scan_idx_q   <= '0;
			any_q        <= 1'b0;
			last_cap_q   <= '0;
			last_delay_q <= '0;
			lf_cap_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				drop_q <= '0;
			end
			if (cmd.mul) begin
				if (draw_q[15]) begin
					last_delay_q <= '0;
				end else if (cfg.quant_step == '0) begin
					last_delay_q <= draw_q[14:0];
				end else if (prod > 27'd32767) begin
					last_delay_q <= 15'h7fff;
				end else begin
					last_delay_q <= prod[14:0];
				end
			end
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_cmp) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (cmd.apply && !skip) begin
				any_q        <= 1'b1;
				last_cap_q   <= best_q.cap;
				lf_cap_q     <= best_q.cap;
				last_delay_q <= best_q.dly;
			end
			if (cmd.rm_wr) begin
				occ_q <= occ_m1;
				if (op_q == OP_ADD) begin
					drop_q <= drop_q + CNT_W'(1);
				end
			end
			if (cmd.insert) begin
				occ_q     <= occ_q + CNT_W'(1);
				arrival_q <= arrival_q + 32'd1;
			end
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic        fv_o;
	logic [15:0] tag_o;
	logic [11:0] wid_o;
	logic [11:0] hgt_o;
	logic [31:0] cap_o;
	logic [14:0] dly_o;
	logic [14:0] exp_o;
	logic [4:0]  drop_o;
	logic [4:0]  cnt_o;

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			fv_o   <= any_q;
			tag_o  <= any_q ? lf_tag_q : '0;
			wid_o  <= any_q ? lf_wid_q : '0;
			hgt_o  <= any_q ? lf_hgt_q : '0;
			cap_o  <= lf_cap_q;
			dly_o  <= any_q ? lf_dly_q : '0;
			exp_o  <= last_delay_q;
			drop_o <= 5'(drop_q);
			cnt_o  <= 5'(occ_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_valid     = fv_o;
	assign out_tag         = tag_o;
	assign out_width       = wid_o;
	assign out_height      = hgt_o;
	assign out_source_time = cap_o;
	assign out_delay       = dly_o;
	assign expected_delay  = exp_o;
	assign dropped_count   = drop_o;
	assign queue_count     = cnt_o;

	always_comb begin
		status             = '0;
		status.is_add      = (op_q == OP_ADD);
		status.div_bypass  = draw_q[15] || (cfg.quant_step == '0);
		status.div_done    = (dcnt_q == DSTEP_W'(DIV_STEPS));
		status.occ_nonzero = (occ_q != '0);
		status.need_drop   = (occ_q != '0) && (occ_q >= limit);
		status.scan_last   = ({1'b0, scan_idx_q} == occ_m1);
		status.due         = (best_q.rel <= {1'b0, now_q});
		status.out_free    = !out_valid_q || out_ready;
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> occ_q < CNT_W'(QUEUE_DEPTH))
		else $error("insert into full queue");
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rm_wr |-> occ_q != '0)
		else $error("remove from empty queue");
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> (!out_valid_q || out_ready))
		else $error("result overwrites pending beat");
endmodule

// ----- rtl/core/delayed_frame_release_queue.sv -----
// top level: apb registers, controller and datapath of the frame release queue
// depends on dfrq_pkg, dfrq_ctrl, dfrq_dp, dfrq_ram
// Each input beat gives one result beat, and a new beat is taken only after the
// previous one is finished. A poll with an empty queue goes straight to the result;
// otherwise every entry scan reads each held entry through the single read port of
// the entry ram, and each released or dropped entry takes a scan of its own. An
// add first runs the bit-serial quantizing divider (skipped when the step is zero
// or the delay negative). The result is held back while out_ready stalls the output.
module delayed_frame_release_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [31:0]       now_time,
	input  logic signed [15:0] delay_ms,
	input  logic [15:0]       frame_tag,
	input  logic [11:0]       frame_width,
	input  logic [11:0]       frame_height,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              frame_valid,
	output logic [15:0]       out_tag,
	output logic [11:0]       out_width,
	output logic [11:0]       out_height,
	output logic [31:0]       out_source_time,
	output logic [14:0]       out_delay,
	output logic [14:0]       expected_delay,
	output logic [4:0]        dropped_count,
	output logic [4:0]        queue_count
);
	import dfrq_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quant_step  <= '0;
			cfg_q.anti_rewind <= 1'b0;
			cfg_q.max_frames  <= 5'd16;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_QUANT_STEP:  cfg_q.quant_step  <= pwdata[9:0];
				REG_ANTI_REWIND: cfg_q.anti_rewind <= pwdata[0];
				REG_MAX_FRAMES:  cfg_q.max_frames  <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_QUANT_STEP:  prdata = {22'd0, cfg_q.quant_step};
			REG_ANTI_REWIND: prdata = {31'd0, cfg_q.anti_rewind};
			REG_MAX_FRAMES:  prdata = {27'd0, cfg_q.max_frames};
			default:         prdata = '0;
		endcase
	end

	dfrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	dfrq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.status          (status),
		.operation       (operation),
		.now_time        (now_time),
		.delay_ms        (delay_ms),
		.frame_tag       (frame_tag),
		.frame_width     (frame_width),
		.frame_height    (frame_height),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_valid     (frame_valid),
		.out_tag         (out_tag),
		.out_width       (out_width),
		.out_height      (out_height),
		.out_source_time (out_source_time),
		.out_delay       (out_delay),
		.expected_delay  (expected_delay),
		.dropped_count   (dropped_count),
		.queue_count     (queue_count)
	);
endmodule

// ----- bench/tb_delayed_frame_release_queue.sv -----
// testbench of the delayed frame release queue: directed table then random beats
// checks every result beat against a behavioral queue predictor; depends on dfrq_pkg
`timescale 1ns / 1ps
module tb_delayed_frame_release_queue;
	import dfrq_pkg::*;

	localparam int WATCHDOG = 20000;

	typedef struct {
		logic        op;
		logic [31:0] now;
		logic [15:0] dly;
		logic [15:0] tag;
		logic [11:0] wid;
		logic [11:0] hgt;
	} beat_t;

	typedef struct {
		logic        fv;
		logic [15:0] tag;
		logic [11:0] wid;
		logic [11:0] hgt;
		logic [31:0] src;
		logic [14:0] dly;
		logic [14:0] xdly;
		logic [4:0]  drop;
		logic [4:0]  cnt;
	} frame_out_t;

	typedef struct {
		logic        chk;
		logic [4:0]  drop;
		logic [4:0]  cnt;
	} known_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic operation = 0;
	logic [31:0] now_time = 0;
	logic signed [15:0] delay_ms = 0;
	logic [15:0] frame_tag = 0;
	logic [11:0] frame_width = 0, frame_height = 0;
	logic out_valid, out_ready = 0;
	logic frame_valid;
	logic [15:0] out_tag;
	logic [11:0] out_width, out_height;
	logic [31:0] out_source_time;
	logic [14:0] out_delay, expected_delay;
	logic [4:0] dropped_count, queue_count;

	delayed_frame_release_queue u_top (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [32:0] q_rel [QUEUE_DEPTH];
	logic [31:0] q_cap [QUEUE_DEPTH];
	logic [14:0] q_dly [QUEUE_DEPTH];
	logic [15:0] q_tag [QUEUE_DEPTH];
	logic [11:0] q_wid [QUEUE_DEPTH];
	logic [11:0] q_hgt [QUEUE_DEPTH];
	logic [31:0] q_ord [QUEUE_DEPTH];
	logic [31:0] arrivals;
	int          held;
	logic [31:0] last_cap;
	frame_out_t  shown;
	logic [9:0]  c_step;
	logic        c_rewind;
	logic [4:0]  c_max;

	frame_out_t expected_frames[$];
	known_t     known_fields[$];
	int errors = 0, idle_cycles = 0;
	int send_idle = 0, recv_stall = 0;

	function automatic bit leaves_first(int a, int b);
		logic [31:0] d;
		if (q_rel[a] != q_rel[b]) return q_rel[a] < q_rel[b];
		d = q_ord[a] - q_ord[b];
		return d[31];
	endfunction

	function automatic int earliest();
		int best;
		best = 0;
		for (int i = 1; i < held; i++) if (leaves_first(i, best)) best = i;
		return best;
	endfunction

	function automatic void drop_at(int i);
		q_rel[i] = q_rel[held-1]; q_cap[i] = q_cap[held-1]; q_dly[i] = q_dly[held-1];
		q_tag[i] = q_tag[held-1]; q_wid[i] = q_wid[held-1]; q_hgt[i] = q_hgt[held-1];
		q_ord[i] = q_ord[held-1];
		held--;
	endfunction

	function automatic logic [14:0] quantize(logic [15:0] raw);
		longint unsigned v, n;
		if (raw[15]) return 0;
		v = raw;
		if (c_step != 0) begin
			n = (2 * v + c_step) / (2 * c_step);
			v = n * c_step;
		end
		if (v > 32767) v = 32767;
		return v[14:0];
	endfunction

	function automatic void predict(beat_t b);
		int i, lim, dropped;
		logic [14:0] d;
		dropped = 0;
		if (b.op == OP_ADD) begin
			d = quantize(b.dly);
			lim = (c_max > QUEUE_DEPTH) ? QUEUE_DEPTH : c_max;
			shown.xdly = d;
			while (held > 0 && held >= lim) begin
				drop_at(earliest());
				dropped++;
			end
			q_rel[held] = {1'b0, b.now} + d; q_cap[held] = b.now; q_dly[held] = d;
			q_tag[held] = b.tag; q_wid[held] = b.wid; q_hgt[held] = b.hgt;
			q_ord[held] = arrivals;
			arrivals++;
			held++;
		end else begin
			while (held > 0) begin
				i = earliest();
				if (q_rel[i] > {1'b0, b.now}) break;
				if (!(c_rewind && shown.fv && q_cap[i] < last_cap)) begin
					shown.fv = 1; shown.tag = q_tag[i]; shown.wid = q_wid[i];
					shown.hgt = q_hgt[i]; shown.src = q_cap[i]; shown.dly = q_dly[i];
					shown.xdly = q_dly[i]; last_cap = q_cap[i];
				end
				drop_at(i);
			end
		end
		shown.drop = dropped[4:0];
		shown.cnt = held[4:0];
		expected_frames = {expected_frames, shown};
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_QUANT_STEP:  c_step = val[9:0];
			REG_ANTI_REWIND: c_rewind = val[0];
			default:         c_max = val[4:0];
		endcase
	endtask

	task automatic send(beat_t b, known_t k);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; operation <= b.op; now_time <= b.now; delay_ms <= b.dly;
		frame_tag <= b.tag; frame_width <= b.wid; frame_height <= b.hgt;
		do @(posedge clk); while (!in_ready);
		predict(b);
		known_fields = {known_fields, k};
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_frames.size() > 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// receiver and checker
	always @(posedge clk) begin
		frame_out_t e;
		known_t k;
		if (out_valid && out_ready) begin
			idle_cycles <= 0;
			if (expected_frames.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_frames.pop_front();
				k = known_fields.pop_front();
				if (k.chk && (k.drop != dropped_count || k.cnt != queue_count)) begin
					$error("table row: dropped %0d/%0d count %0d/%0d", k.drop,
						dropped_count, k.cnt, queue_count);
					errors++;
				end
				if (frame_valid !== e.fv) begin
					$error("frame_valid exp %0h got %0h", e.fv, frame_valid); errors++; end
				if (out_tag !== e.tag) begin
					$error("out_tag exp %0h got %0h", e.tag, out_tag); errors++; end
				if (out_width !== e.wid) begin
					$error("out_width exp %0h got %0h", e.wid, out_width); errors++; end
				if (out_height !== e.hgt) begin
					$error("out_height exp %0h got %0h", e.hgt, out_height); errors++; end
				if (out_source_time !== e.src) begin
					$error("out_source_time exp %0h got %0h", e.src, out_source_time);
					errors++;
				end
				if (out_delay !== e.dly) begin
					$error("out_delay exp %0h got %0h", e.dly, out_delay); errors++; end
				if (expected_delay !== e.xdly) begin
					$error("expected_delay exp %0h got %0h", e.xdly, expected_delay);
					errors++;
				end
				if (dropped_count !== e.drop) begin
					$error("dropped_count exp %0h got %0h", e.drop, dropped_count); errors++; end
				if (queue_count !== e.cnt) begin
					$error("queue_count exp %0h got %0h", e.cnt, queue_count); errors++; end
			end
		end else if (in_valid && in_ready) idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAIL delayed_frame_release_queue");
				$finish;
			end
		end
		out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	function automatic beat_t rand_beat(logic [31:0] base);
		beat_t b;
		b.op = $urandom_range(99) < 40;
		b.now = ($urandom_range(19) == 0) ? $urandom : base;
		case ($urandom_range(5))
			0: b.dly = 16'($urandom);
			1: b.dly = -$signed(16'($urandom_range(30000)));
			2: b.dly = 16'($urandom_range(100));
			default: b.dly = 16'($urandom_range(3000));
		endcase
		b.tag = 16'($urandom); b.wid = 12'($urandom); b.hgt = 12'($urandom);
		return b;
	endfunction

	beat_t  rows [20];
	known_t keys [20];
	beat_t  b;
	logic [31:0] clock_ms;
	known_t none;

	initial begin
		shown = '{default: 0};
		arrivals = 0; held = 0; last_cap = 0;
		c_step = 0; c_rewind = 0; c_max = 16;
		none = '{chk: 0, drop: 0, cnt: 0};
		// directed rows
		rows[0] = '{OP_POLL, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0};
		keys[0] = '{1, 0, 0};
		rows[1] = '{OP_ADD, 32'd100, 16'd0, 16'hffff, 12'hfff, 12'hfff};
		keys[1] = '{1, 0, 1};
		rows[2] = '{OP_ADD, 32'd100, 16'h7fff, 16'h0001, 12'd1, 12'd2};
		keys[2] = '{1, 0, 2};
		rows[3] = '{OP_ADD, 32'd100, 16'h8000, 16'h0002, 12'd3, 12'd4};
		keys[3] = '{1, 0, 3};
		rows[4] = '{OP_ADD, 32'hffffffff, 16'd30000, 16'h0003, 12'd5, 12'd6};
		keys[4] = '{1, 0, 4};
		rows[5] = '{OP_POLL, 32'd100, 16'd0, 16'd0, 12'd0, 12'd0};
		keys[5] = none;
		rows[6] = '{OP_ADD, 32'd50, 16'd10, 16'h0004, 12'd7, 12'd8};
		keys[6] = none;
		rows[7] = '{OP_ADD, 32'd60, 16'd0, 16'h0005, 12'd9, 12'd10};
		keys[7] = none;
		rows[8] = '{OP_POLL, 32'd60, 16'd0, 16'd0, 12'd0, 12'd0};
		keys[8] = none;
		rows[9] = '{OP_POLL, 32'hffffffff, 16'd0, 16'd0, 12'd0, 12'd0};
		keys[9] = none;
		for (int i = 10; i < 20; i++) begin
			rows[i] = '{OP_ADD, 32'd1000, 16'(i * 37), 16'(i), 12'(i), 12'(i)};
			keys[i] = none;
		end
		rows[19].op = OP_POLL; rows[19].now = 32'd2000;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 10; i++) send(rows[i], keys[i]);
		drain();
		// rounding, anti-rewind and small limits
		cfg_write(REG_QUANT_STEP, 100);
		cfg_write(REG_ANTI_REWIND, 1);
		cfg_write(REG_MAX_FRAMES, 3);
		for (int i = 10; i < 20; i++) send(rows[i], keys[i]);
		drain();
		cfg_write(REG_MAX_FRAMES, 0);
		send('{OP_ADD, 32'd5, 16'd150, 16'h10, 12'd1, 12'd1}, '{1, 1, 1});
		drain();
		// random phases with varying settings and idling
		clock_ms = 1000;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 81; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 81; end
				default: begin send_idle = 17; recv_stall = 17; end
			endcase
			cfg_write(REG_QUANT_STEP, (ph == 3) ? 1000 : (ph == 5) ? 1 :
				(ph % 2) ? $urandom_range(1023) : 0);
			cfg_write(REG_ANTI_REWIND, ph[0]);
			cfg_write(REG_MAX_FRAMES, (ph == 2) ? 1 : (ph == 6) ? 31 : $urandom_range(31));
			for (int n = 0; n < 85; n++) begin
				clock_ms += $urandom_range(400);
				b = rand_beat(clock_ms);
				send(b, none);
			end
			drain();
		end
		if (errors == 0)
			$display("PASS delayed_frame_release_queue");
		else
			$display("FAIL delayed_frame_release_queue");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/dfrq_pkg.sv
rtl/core/dfrq_ram.sv
rtl/core/dfrq_ctrl.sv
rtl/core/dfrq_dp.sv
rtl/core/delayed_frame_release_queue.sv
bench/tb_delayed_frame_release_queue.sv
